/* sv/pcc_pkg.sv */
// ----------------------------------------------------------------------------
// pcc_pkg
// shared types, codes and constants of the path clearance checker
// ----------------------------------------------------------------------------
package pcc_pkg;

    localparam int DEF_ZONE_COUNT  = 16;
    localparam int DEF_COORD_WIDTH = 18;

    // 180 and 360 degrees at 1/256 degree per lsb
    localparam int HALF_TURN  = 46080;
    localparam int FULL_TURN  = 92160;
    // signed width that holds the seam azimuth
    localparam int SEAM_WIDTH = 18;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MOTION_PROFILE = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_AZIMUTH_WRAPS  = 2'd1;

    localparam logic [1:0] PROFILE_LINEAR   = 2'd0;
    localparam logic [1:0] PROFILE_AZ_FIRST = 2'd1;
    localparam logic [1:0] PROFILE_EL_FIRST = 2'd2;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_CHECK = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_CLASSIFY,
        ST_DIVIDE,
        ST_WAIT,
        ST_DONE
    } pcc_state_t;

    typedef struct packed {
        logic valid;
        logic hit;
    } pcc_tok_ctl_t;

    function automatic int point_width(input int coord_width);
        return (coord_width > SEAM_WIDTH) ? coord_width : SEAM_WIDTH;
    endfunction

endpackage

/* sv/pcc_zone_cell.sv */
// ----------------------------------------------------------------------------
// pcc_zone_cell
// one zone of the table: holds its bounds and clips a passing segment
// against them in two stages, then hands the segment to the next cell
// ----------------------------------------------------------------------------
module pcc_zone_cell
    import pcc_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              ld_we,
    input  logic                              ld_enable,
    input  logic signed [COORD_WIDTH-1:0]     ld_az_low,
    input  logic signed [COORD_WIDTH-1:0]     ld_az_high,
    input  logic signed [COORD_WIDTH-1:0]     ld_el_low,
    input  logic signed [COORD_WIDTH-1:0]     ld_el_high,
    input  pcc_tok_ctl_t                      in_ctl,
    input  logic signed [point_width(COORD_WIDTH)-1:0] in_x0,
    input  logic signed [point_width(COORD_WIDTH)-1:0] in_y0,
    input  logic [point_width(COORD_WIDTH):0] in_dx,
    input  logic                              in_dx_neg,
    input  logic [point_width(COORD_WIDTH):0] in_dy,
    input  logic                              in_dy_neg,
    output pcc_tok_ctl_t                      out_ctl,
    output logic signed [point_width(COORD_WIDTH)-1:0] out_x0,
    output logic signed [point_width(COORD_WIDTH)-1:0] out_y0,
    output logic [point_width(COORD_WIDTH):0] out_dx,
    output logic                              out_dx_neg,
    output logic [point_width(COORD_WIDTH):0] out_dy,
    output logic                              out_dy_neg
);

    localparam int PW = point_width(COORD_WIDTH);
    localparam int DW = PW + 1;
    localparam int EW = PW + 2;

    typedef struct packed {
        logic          ok;
        logic [DW-1:0] en;
        logic [DW-1:0] ex;
        logic [DW-1:0] d;
    } axis_t;

    function automatic axis_t clip_axis(
        input logic signed [PW-1:0]          p,
        input logic signed [COORD_WIDTH-1:0] lo,
        input logic signed [COORD_WIDTH-1:0] hi,
        input logic [DW-1:0]                 d,
        input logic                          neg
    );
        axis_t                r;
        logic signed [EW-1:0] pe;
        logic signed [EW-1:0] loe;
        logic signed [EW-1:0] hie;
        logic signed [EW-1:0] de;
        logic signed [EW-1:0] a;
        logic signed [EW-1:0] b;
        logic signed [EW-1:0] en;
        logic signed [EW-1:0] ex;
        pe  = EW'(p);
        loe = EW'(lo);
        hie = EW'(hi);
        de  = $signed({1'b0, d});
        if (d == '0)
        begin
            // still axis
            r.ok = (pe > loe) && (pe < hie);
            r.en = '0;
            r.ex = DW'(1);
            r.d  = DW'(1);
        end
        else
        begin
            if (neg)
            begin
                a = pe - loe;
                b = pe - hie;
            end
            else
            begin
                a = loe - pe;
                b = hie - pe;
            end
            en = (a < b) ? a : b;
            ex = (a < b) ? b : a;
            if (en < 0)
            begin
                en = '0;
            end
            if (en > de)
            begin
                en = de;
            end
            if (ex < 0)
            begin
                ex = '0;
            end
            if (ex > de)
            begin
                ex = de;
            end
            r.ok = 1'b1;
            r.en = en[DW-1:0];
            r.ex = ex[DW-1:0];
            r.d  = d;
        end
        return r;
    endfunction

    logic                          valid_reg;
    logic signed [COORD_WIDTH-1:0] az_low_reg;
    logic signed [COORD_WIDTH-1:0] az_high_reg;
    logic signed [COORD_WIDTH-1:0] el_low_reg;
    logic signed [COORD_WIDTH-1:0] el_high_reg;

    pcc_tok_ctl_t         a_ctl_reg;
    logic signed [PW-1:0] a_x0_reg;
    logic signed [PW-1:0] a_y0_reg;
    logic [DW-1:0]        a_dx_reg;
    logic                 a_dx_neg_reg;
    logic [DW-1:0]        a_dy_reg;
    logic                 a_dy_neg_reg;
    axis_t                a_ax_reg;
    axis_t                a_ay_reg;
    logic                 a_live_reg;

    pcc_tok_ctl_t         b_ctl_reg;
    pcc_tok_ctl_t         b_ctl_next;
    logic signed [PW-1:0] b_x0_reg;
    logic signed [PW-1:0] b_y0_reg;
    logic [DW-1:0]        b_dx_reg;
    logic                 b_dx_neg_reg;
    logic [DW-1:0]        b_dy_reg;
    logic                 b_dy_neg_reg;

    axis_t                ax_next;
    axis_t                ay_next;
    logic [2*DW-1:0]      prod_nx_dy;
    logic [2*DW-1:0]      prod_xy_dx;
    logic [2*DW-1:0]      prod_ny_dx;
    logic [2*DW-1:0]      prod_xx_dy;
    logic                 hit_here;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ld_we)
        begin
            valid_reg <= ld_enable;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_we)
        begin
            az_low_reg  <= ld_az_low;
            az_high_reg <= ld_az_high;
            el_low_reg  <= ld_el_low;
            el_high_reg <= ld_el_high;
        end
    end

    // stage a: entry and exit parameters per axis
    always_comb
    begin
        ax_next = clip_axis(in_x0, az_low_reg, az_high_reg, in_dx, in_dx_neg);
        ay_next = clip_axis(in_y0, el_low_reg, el_high_reg, in_dy, in_dy_neg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ctl_reg <= '0;
            b_ctl_reg <= '0;
        end
        else
        begin
            a_ctl_reg <= in_ctl;
            b_ctl_reg <= b_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_x0_reg     <= in_x0;
        a_y0_reg     <= in_y0;
        a_dx_reg     <= in_dx;
        a_dx_neg_reg <= in_dx_neg;
        a_dy_reg     <= in_dy;
        a_dy_neg_reg <= in_dy_neg;
        a_ax_reg     <= ax_next;
        a_ay_reg     <= ay_next;
        a_live_reg   <= valid_reg;
        b_x0_reg     <= a_x0_reg;
        b_y0_reg     <= a_y0_reg;
        b_dx_reg     <= a_dx_reg;
        b_dx_neg_reg <= a_dx_neg_reg;
        b_dy_reg     <= a_dy_reg;
        b_dy_neg_reg <= a_dy_neg_reg;
    end

    // stage b: latest entry before earliest exit, cross-multiplied
    always_comb
    begin
        prod_nx_dy = a_ax_reg.en * a_ay_reg.d;
        prod_xy_dx = a_ay_reg.ex * a_ax_reg.d;
        prod_ny_dx = a_ay_reg.en * a_ax_reg.d;
        prod_xx_dy = a_ax_reg.ex * a_ay_reg.d;
        hit_here   = a_live_reg && a_ax_reg.ok && a_ay_reg.ok
                     && (a_ax_reg.en < a_ax_reg.ex) && (a_ay_reg.en < a_ay_reg.ex)
                     && (prod_nx_dy < prod_xy_dx) && (prod_ny_dx < prod_xx_dy);
        b_ctl_next.valid = a_ctl_reg.valid;
        b_ctl_next.hit   = a_ctl_reg.hit || (a_ctl_reg.valid && hit_here);
    end

    assign out_ctl    = b_ctl_reg;
    assign out_x0     = b_x0_reg;
    assign out_y0     = b_y0_reg;
    assign out_dx     = b_dx_reg;
    assign out_dx_neg = b_dx_neg_reg;
    assign out_dy     = b_dy_reg;
    assign out_dy_neg = b_dy_neg_reg;

endmodule

/* sv/pcc_divider.sv */
// ----------------------------------------------------------------------------
// pcc_divider
// rounded num * mul / den, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pcc_divider
    import pcc_pkg::*;
#(
    parameter int DW = DEF_COORD_WIDTH + 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] num,
    input  logic [DW-1:0] mul,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [DW-1:0] quot
);

    localparam int PBW = 2 * DW;
    localparam int CW  = $clog2(PBW + 1);

    logic           run_reg;
    logic           done_reg;
    logic [CW-1:0]  cnt_reg;
    logic [PBW-1:0] prod_reg;
    logic [DW-1:0]  den_reg;
    logic [DW-1:0]  rem_reg;
    logic [DW-1:0]  quot_reg;

    logic [DW:0]    trial;
    logic           take;
    logic           round_up;

    always_comb
    begin
        trial    = {rem_reg, prod_reg[PBW-1]};
        take     = trial >= {1'b0, den_reg};
        round_up = {rem_reg, 1'b0} >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(PBW);
            end
            else if (run_reg)
            begin
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= num * mul;
            den_reg  <= den;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (run_reg)
        begin
            if (cnt_reg == '0)
            begin
                quot_reg <= quot_reg + DW'(round_up);
            end
            else
            begin
                prod_reg <= {prod_reg[PBW-2:0], 1'b0};
                rem_reg  <= take ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
                quot_reg <= {quot_reg[DW-2:0], take};
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

/* sv/path_clearance_checker_core.sv */
// ----------------------------------------------------------------------------
// path_clearance_checker_core
// zone table as a chain of clip cells; a sequencer walks the path segments,
// splits them at the azimuth seam and collects hits from the chain end
// ----------------------------------------------------------------------------
// load: taken in the transfer cycle, busy stays low, no result
// check: each straight segment passes once through the cell chain,
//   a seam split adds a divider run plus a second pass
// a check holds busy until its done strobe, so one check is in flight at a time
// done is shown for one cycle and path_clear holds until the next check starts; the receiver cannot stall
// reset clears the zone valid bits, the configuration registers and the sequencer
module path_clearance_checker_core
    import pcc_pkg::*;
#(
    parameter int ZONE_COUNT  = DEF_ZONE_COUNT,
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          req_type,
    input  logic [3:0]                    zone_slot,
    input  logic                          zone_enable,
    input  logic signed [COORD_WIDTH-1:0] zone_az_low,
    input  logic signed [COORD_WIDTH-1:0] zone_az_high,
    input  logic signed [COORD_WIDTH-1:0] zone_el_low,
    input  logic signed [COORD_WIDTH-1:0] zone_el_high,
    input  logic signed [COORD_WIDTH-1:0] start_az,
    input  logic signed [COORD_WIDTH-1:0] start_el,
    input  logic signed [COORD_WIDTH-1:0] end_az,
    input  logic signed [COORD_WIDTH-1:0] end_el,
    output logic                          done,
    output logic                          path_clear,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]     cfg_data
);

    localparam int PW = point_width(COORD_WIDTH);
    localparam int DW = PW + 1;
    localparam int EW = PW + 2;

    localparam logic signed [PW-1:0] SEAM     = PW'(HALF_TURN);
    localparam logic signed [DW-1:0] HALF_D   = DW'(HALF_TURN);
    localparam logic signed [EW-1:0] FULL_E   = EW'(FULL_TURN);

    pcc_state_t state_reg;
    pcc_state_t state_next;

    logic [1:0] profile_reg;
    logic       wrap_reg;

    logic signed [PW-1:0] az0_reg, az0_next;
    logic signed [PW-1:0] el0_reg, el0_next;
    logic signed [PW-1:0] az1_reg, az1_next;
    logic signed [PW-1:0] el1_reg, el1_next;
    logic [1:0]           seg_reg, seg_next;
    logic signed [PW-1:0] sx0_reg, sx0_next;
    logic signed [PW-1:0] sy0_reg, sy0_next;
    logic signed [PW-1:0] sx1_reg, sx1_next;
    logic signed [PW-1:0] sy1_reg, sy1_next;
    logic signed [PW-1:0] bnd_reg, bnd_next;
    logic signed [PW-1:0] ys_reg, ys_next;
    logic [DW-1:0]        num_reg, num_next;
    logic [DW-1:0]        eff_reg, eff_next;
    logic [DW-1:0]        m_reg, m_next;
    logic                 dyneg_reg, dyneg_next;
    logic                 part_reg, part_next;
    logic                 hit_reg, hit_next;
    logic                 div_start_reg, div_start_next;

    logic                 tk_valid_reg;
    logic signed [PW-1:0] tk_x0_reg;
    logic signed [PW-1:0] tk_y0_reg;
    logic [DW-1:0]        tk_dx_reg;
    logic                 tk_dx_neg_reg;
    logic [DW-1:0]        tk_dy_reg;
    logic                 tk_dy_neg_reg;

    logic                 iss_en;
    logic signed [PW-1:0] iss_x0, iss_y0, iss_x1, iss_y1;
    logic signed [DW-1:0] iss_dx, iss_dy;

    logic signed [PW-1:0] sel_x0, sel_y0, sel_x1, sel_y1;
    logic                 seg_last;

    logic signed [DW-1:0] cl_daz;
    logic signed [DW-1:0] cl_dy;
    logic signed [EW-1:0] cl_eff_s;
    logic signed [EW-1:0] cl_num_s;
    logic signed [EW-1:0] cl_eff_abs;
    logic signed [PW-1:0] cl_bnd;
    logic                 cl_split;
    logic                 cl_zero;

    logic                 div_done;
    logic [DW-1:0]        div_quot;

    logic                 load_fire;
    logic                 check_fire;

    pcc_tok_ctl_t         ch_ctl    [ZONE_COUNT+1];
    logic signed [PW-1:0] ch_x0     [ZONE_COUNT+1];
    logic signed [PW-1:0] ch_y0     [ZONE_COUNT+1];
    logic [DW-1:0]        ch_dx     [ZONE_COUNT+1];
    logic                 ch_dx_neg [ZONE_COUNT+1];
    logic [DW-1:0]        ch_dy     [ZONE_COUNT+1];
    logic                 ch_dy_neg [ZONE_COUNT+1];

    assign load_fire  = start && !busy && (req_type == REQ_LOAD);
    assign check_fire = start && !busy && (req_type == REQ_CHECK);
    assign cfg_ready  = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            profile_reg <= PROFILE_LINEAR;
            wrap_reg    <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MOTION_PROFILE: profile_reg <= cfg_data[1:0];
                REG_AZIMUTH_WRAPS:  wrap_reg    <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // segment endpoints for the current profile
    always_comb
    begin
        sel_x0 = az0_reg;
        sel_y0 = el0_reg;
        sel_x1 = az1_reg;
        sel_y1 = el1_reg;
        case (profile_reg)
            PROFILE_AZ_FIRST:
            begin
                seg_last = (seg_reg == 2'd1);
                if (seg_reg == 2'd0)
                begin
                    sel_y1 = el0_reg;
                end
                else
                begin
                    sel_x0 = az1_reg;
                end
            end
            PROFILE_EL_FIRST:
            begin
                seg_last = (seg_reg == 2'd1);
                if (seg_reg == 2'd0)
                begin
                    sel_x1 = az0_reg;
                end
                else
                begin
                    sel_y0 = el1_reg;
                end
            end
            default:
            begin
                seg_last = (seg_reg == 2'd2);
                if (seg_reg == 2'd1)
                begin
                    sel_y0 = el1_reg;
                end
                else if (seg_reg == 2'd2)
                begin
                    sel_x0 = az1_reg;
                end
            end
        endcase
    end

    // seam classification of the latched segment
    always_comb
    begin
        cl_daz   = DW'(sx1_reg) - DW'(sx0_reg);
        cl_dy    = DW'(sy1_reg) - DW'(sy0_reg);
        cl_split = wrap_reg && ((cl_daz > HALF_D) || (cl_daz < -HALF_D));
        if (cl_daz < -HALF_D)
        begin
            cl_eff_s = EW'(cl_daz) + FULL_E;
            cl_bnd   = SEAM;
        end
        else
        begin
            cl_eff_s = EW'(cl_daz) - FULL_E;
            cl_bnd   = -SEAM;
        end
        cl_zero  = (cl_eff_s == '0);
        cl_num_s = EW'(cl_bnd) - EW'(sx0_reg);
        if (cl_eff_s < 0)
        begin
            cl_eff_abs = -cl_eff_s;
            cl_num_s   = -cl_num_s;
        end
        else
        begin
            cl_eff_abs = cl_eff_s;
        end
        if (cl_num_s < 0)
        begin
            cl_num_s = '0;
        end
        if (cl_num_s > cl_eff_abs)
        begin
            cl_num_s = cl_eff_abs;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (check_fire)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = ST_CLASSIFY;
            end
            ST_CLASSIFY:
            begin
                if (!cl_split)
                begin
                    state_next = ST_WAIT;
                end
                else if (!cl_zero)
                begin
                    state_next = ST_DIVIDE;
                end
                else
                begin
                    state_next = seg_last ? ST_DONE : ST_SETUP;
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (ch_ctl[ZONE_COUNT].valid && !part_reg)
                begin
                    state_next = seg_last ? ST_DONE : ST_SETUP;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and token issue
    always_comb
    begin
        az0_next       = az0_reg;
        el0_next       = el0_reg;
        az1_next       = az1_reg;
        el1_next       = el1_reg;
        seg_next       = seg_reg;
        sx0_next       = sx0_reg;
        sy0_next       = sy0_reg;
        sx1_next       = sx1_reg;
        sy1_next       = sy1_reg;
        bnd_next       = bnd_reg;
        ys_next        = ys_reg;
        num_next       = num_reg;
        eff_next       = eff_reg;
        m_next         = m_reg;
        dyneg_next     = dyneg_reg;
        part_next      = part_reg;
        hit_next       = hit_reg;
        div_start_next = 1'b0;
        iss_en         = 1'b0;
        iss_x0         = sx0_reg;
        iss_y0         = sy0_reg;
        iss_x1         = sx1_reg;
        iss_y1         = sy1_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (check_fire)
                begin
                    az0_next  = PW'(start_az);
                    el0_next  = PW'(start_el);
                    az1_next  = PW'(end_az);
                    el1_next  = PW'(end_el);
                    seg_next  = 2'd0;
                    hit_next  = 1'b0;
                    part_next = 1'b0;
                end
            end
            ST_SETUP:
            begin
                sx0_next = sel_x0;
                sy0_next = sel_y0;
                sx1_next = sel_x1;
                sy1_next = sel_y1;
            end
            ST_CLASSIFY:
            begin
                if (!cl_split)
                begin
                    iss_en    = 1'b1;
                    part_next = 1'b0;
                end
                else if (!cl_zero)
                begin
                    num_next       = cl_num_s[DW-1:0];
                    eff_next       = cl_eff_abs[DW-1:0];
                    m_next         = (cl_dy < 0) ? DW'(-cl_dy) : DW'(cl_dy);
                    dyneg_next     = cl_dy < 0;
                    bnd_next       = cl_bnd;
                    div_start_next = 1'b1;
                end
                else if (!seg_last)
                begin
                    seg_next = seg_reg + 2'd1;
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    ys_next   = dyneg_reg ? sy0_reg - PW'(div_quot) : sy0_reg + PW'(div_quot);
                    iss_en    = 1'b1;
                    iss_x1    = bnd_reg;
                    iss_y1    = ys_next;
                    part_next = 1'b1;
                end
            end
            ST_WAIT:
            begin
                if (ch_ctl[ZONE_COUNT].valid)
                begin
                    hit_next = hit_reg || ch_ctl[ZONE_COUNT].hit;
                    if (part_reg)
                    begin
                        iss_en    = 1'b1;
                        iss_x0    = -bnd_reg;
                        iss_y0    = ys_reg;
                        part_next = 1'b0;
                    end
                    else if (!seg_last)
                    begin
                        seg_next = seg_reg + 2'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        iss_dx = DW'(iss_x1) - DW'(iss_x0);
        iss_dy = DW'(iss_y1) - DW'(iss_y0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seg_reg       <= 2'd0;
            part_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            div_start_reg <= 1'b0;
            tk_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seg_reg       <= seg_next;
            part_reg      <= part_next;
            hit_reg       <= hit_next;
            div_start_reg <= div_start_next;
            tk_valid_reg  <= iss_en;
        end
    end

    always_ff @(posedge clk)
    begin
        az0_reg       <= az0_next;
        el0_reg       <= el0_next;
        az1_reg       <= az1_next;
        el1_reg       <= el1_next;
        sx0_reg       <= sx0_next;
        sy0_reg       <= sy0_next;
        sx1_reg       <= sx1_next;
        sy1_reg       <= sy1_next;
        bnd_reg       <= bnd_next;
        ys_reg        <= ys_next;
        num_reg       <= num_next;
        eff_reg       <= eff_next;
        m_reg         <= m_next;
        dyneg_reg     <= dyneg_next;
        tk_x0_reg     <= iss_x0;
        tk_y0_reg     <= iss_y0;
        tk_dx_reg     <= (iss_dx < 0) ? DW'(-iss_dx) : DW'(iss_dx);
        tk_dx_neg_reg <= iss_dx < 0;
        tk_dy_reg     <= (iss_dy < 0) ? DW'(-iss_dy) : DW'(iss_dy);
        tk_dy_neg_reg <= iss_dy < 0;
    end

    pcc_divider #(
        .DW (DW)
    ) u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (num_reg),
        .mul   (m_reg),
        .den   (eff_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign ch_ctl[0].valid = tk_valid_reg;
    assign ch_ctl[0].hit   = 1'b0;
    assign ch_x0[0]        = tk_x0_reg;
    assign ch_y0[0]        = tk_y0_reg;
    assign ch_dx[0]        = tk_dx_reg;
    assign ch_dx_neg[0]    = tk_dx_neg_reg;
    assign ch_dy[0]        = tk_dy_reg;
    assign ch_dy_neg[0]    = tk_dy_neg_reg;

    for (genvar i = 0; i < ZONE_COUNT; i++)
    begin : g_cell
        pcc_zone_cell #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ld_we      (load_fire && ({28'd0, zone_slot} == 32'(i))),
            .ld_enable  (zone_enable),
            .ld_az_low  (zone_az_low),
            .ld_az_high (zone_az_high),
            .ld_el_low  (zone_el_low),
            .ld_el_high (zone_el_high),
            .in_ctl     (ch_ctl[i]),
            .in_x0      (ch_x0[i]),
            .in_y0      (ch_y0[i]),
            .in_dx      (ch_dx[i]),
            .in_dx_neg  (ch_dx_neg[i]),
            .in_dy      (ch_dy[i]),
            .in_dy_neg  (ch_dy_neg[i]),
            .out_ctl    (ch_ctl[i+1]),
            .out_x0     (ch_x0[i+1]),
            .out_y0     (ch_y0[i+1]),
            .out_dx     (ch_dx[i+1]),
            .out_dx_neg (ch_dx_neg[i+1]),
            .out_dy     (ch_dy[i+1]),
            .out_dy_neg (ch_dy_neg[i+1])
        );
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = (state_reg == ST_DONE);
    assign path_clear = !hit_reg;

    a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    a_chain_quiet_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !ch_ctl[ZONE_COUNT].valid)
        else $error("segment leaves the chain while idle");

    a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
        tk_valid_reg |=> !tk_valid_reg)
        else $error("two segments issued back to back");

    a_div_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIVIDE))
        else $error("divider finished outside the divide state");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the path clearance checker: loads zone tables,
// checks paths under every motion profile and wrap setting, and compares
// each path_clear against an exact in-bench clip predictor
// ----------------------------------------------------------------------------
module tb;
    import pcc_pkg::*;

    localparam int ZN = DEF_ZONE_COUNT;
    localparam int CW = DEF_COORD_WIDTH;

    typedef logic signed [CW-1:0] coord_t;

    class clearance_board;
        logic [1:0] profile;
        logic       wraps;
        bit         zone_on [ZN];
        longint     az_lo [ZN], az_hi [ZN], el_lo [ZN], el_hi [ZN];
        bit         clear_q [$];
        int         checks_seen;
        int         loads_seen;

        function new();
            profile = PROFILE_LINEAR;
            wraps = 1'b0;
            foreach (zone_on[i]) zone_on[i] = 0;
            checks_seen = 0;
            loads_seen = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_WIDTH-1:0] idx,
                              logic [CFG_DATA_WIDTH-1:0] val);
            if (idx == REG_MOTION_PROFILE) profile = val;
            else if (idx == REG_AZIMUTH_WRAPS) wraps = val[0];
        endfunction

        function int frac_order(longint xn, longint xd, longint yn, longint yd);
            longint a, b;
            a = xn * yd;
            b = yn * xd;
            return (a < b) ? -1 : ((a > b) ? 1 : 0);
        endfunction

        function bit clip_span(longint p0, longint p1, longint lo, longint hi,
                               inout longint nn, inout longint nd,
                               inout longint fn, inout longint fd);
            longint d, a, b, en, ex;
            d = p1 - p0;
            if (d == 0) return !(p0 <= lo || p0 >= hi);
            if (d > 0) begin a = lo - p0; b = hi - p0; end
            else begin a = p0 - lo; b = p0 - hi; d = -d; end
            en = (a < b) ? a : b;
            ex = (a < b) ? b : a;
            if (en < 0) en = 0;
            if (en > d) en = d;
            if (ex < 0) ex = 0;
            if (ex > d) ex = d;
            if (frac_order(en, d, nn, nd) > 0) begin nn = en; nd = d; end
            if (frac_order(ex, d, fn, fd) < 0) begin fn = ex; fd = d; end
            return frac_order(nn, nd, fn, fd) < 0;
        endfunction

        function bit leg_clear(longint x0, longint y0, longint x1, longint y1);
            longint nn, nd, fn, fd;
            for (int z = 0; z < ZN; z++) begin
                if (!zone_on[z]) continue;
                nn = 0; nd = 1; fn = 1; fd = 1;
                if (clip_span(x0, x1, az_lo[z], az_hi[z], nn, nd, fn, fd) &&
                    clip_span(y0, y1, el_lo[z], el_hi[z], nn, nd, fn, fd))
                    return 0;
            end
            return 1;
        endfunction

        function bit arc_clear(longint x0, longint y0, longint x1, longint y1);
            longint daz, eff, bnd, num, dy, ady, q, r, ys;
            daz = x1 - x0;
            if (!wraps || (daz <= HALF_TURN && daz >= -HALF_TURN))
                return leg_clear(x0, y0, x1, y1);
            if (daz < -HALF_TURN) begin eff = daz + FULL_TURN; bnd = HALF_TURN; end
            else begin eff = daz - FULL_TURN; bnd = -HALF_TURN; end
            if (eff == 0) return 1;
            num = bnd - x0;
            if (eff < 0) begin eff = -eff; num = -num; end
            if (num < 0) num = 0;
            if (num > eff) num = eff;
            dy = y1 - y0;
            ady = (dy < 0) ? -dy : dy;
            q = (num * ady) / eff;
            r = num * ady - q * eff;
            if (2 * r >= eff) q++;
            ys = (dy < 0) ? y0 - q : y0 + q;
            if (!leg_clear(x0, y0, bnd, ys)) return 0;
            return leg_clear(-bnd, ys, x1, y1);
        endfunction

        function bit route_clear(longint a0, longint e0, longint a1, longint e1);
            case (profile)
                PROFILE_AZ_FIRST:
                    return arc_clear(a0, e0, a1, e0) && arc_clear(a1, e0, a1, e1);
                PROFILE_EL_FIRST:
                    return arc_clear(a0, e0, a0, e1) && arc_clear(a0, e1, a1, e1);
                default:
                    return arc_clear(a0, e0, a1, e1) && arc_clear(a0, e1, a1, e1) &&
                           arc_clear(a1, e0, a1, e1);
            endcase
        endfunction

        function void note(logic rt, logic [3:0] slot, logic en,
                           coord_t azl, coord_t azh, coord_t ell, coord_t elh,
                           coord_t sa, coord_t se, coord_t ea, coord_t ee);
            if (rt == REQ_LOAD) begin
                loads_seen++;
                zone_on[slot] = en;
                az_lo[slot] = azl; az_hi[slot] = azh;
                el_lo[slot] = ell; el_hi[slot] = elh;
            end else begin
                clear_q.push_back(route_clear(sa, se, ea, ee));
            end
        endfunction

        // 0 match, 1 wrong value, 2 nothing expected
        function int check(logic got, output bit want);
            want = 0;
            if (clear_q.size() == 0) return 2;
            want = clear_q.pop_front();
            checks_seen++;
            return (got === want) ? 0 : 1;
        endfunction
    endclass

    logic clk, rst_n;
    logic start, busy, done, path_clear;
    logic req_type, zone_enable;
    logic [3:0] zone_slot;
    coord_t zone_az_low, zone_az_high, zone_el_low, zone_el_high;
    coord_t start_az, start_el, end_az, end_el;
    logic cfg_valid, cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;

    clearance_board board;
    int errors;

    path_clearance_checker_core dut (.*);

    always
    begin
        clk = 1'b0; #4;
        clk = 1'b1; #4;
    end

    task automatic report(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            board.note(req_type, zone_slot, zone_enable, zone_az_low, zone_az_high,
                       zone_el_low, zone_el_high, start_az, start_el, end_az, end_el);
        if (rst_n && cfg_valid && cfg_ready)
            board.set_reg(cfg_index, cfg_data);
    end

    always @(posedge clk)
    begin
        bit want;
        int r;
        if (rst_n && done) begin
            r = board.check(path_clear, want);
            if (r == 2) report("path_clear with no check outstanding");
            else if (r == 1) report($sformatf("path_clear %0b, expected %0b",
                                              path_clear, want));
        end
    end

    task automatic idle_gap();
        int g;
        g = ($urandom_range(0, 9) < 6) ? 0 :
            (($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4));
        if (g > 0) begin
            start <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic transfer(logic rt, logic [3:0] slot, logic en,
                            coord_t azl, coord_t azh, coord_t ell, coord_t elh,
                            coord_t sa, coord_t se, coord_t ea, coord_t ee);
        req_type <= rt; zone_slot <= slot; zone_enable <= en;
        zone_az_low <= azl; zone_az_high <= azh;
        zone_el_low <= ell; zone_el_high <= elh;
        start_az <= sa; start_el <= se; end_az <= ea; end_el <= ee;
        start <= 1'b1;
        do @(posedge clk); while (busy);
    endtask

    task automatic load_zone(logic [3:0] slot, logic en, coord_t azl, coord_t azh,
                             coord_t ell, coord_t elh);
        transfer(REQ_LOAD, slot, en, azl, azh, ell, elh,
                 coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                 coord_t'($urandom));
    endtask

    task automatic check_path(coord_t sa, coord_t se, coord_t ea, coord_t ee);
        transfer(REQ_CHECK, 4'($urandom), 1'($urandom), coord_t'($urandom),
                 coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                 sa, se, ea, ee);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (busy || board.clear_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx,
                             logic [CFG_DATA_WIDTH-1:0] val);
        cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic coord_t pick_coord();
        int k;
        k = $urandom_range(0, 9);
        if (k < 6) return coord_t'($signed($urandom_range(0, 100000)) - 50000);
        if (k < 9) return coord_t'(($urandom_range(0, 1) ? HALF_TURN : -HALF_TURN) +
                                   $signed($urandom_range(0, 4000)) - 2000);
        return coord_t'($urandom);
    endfunction

    task automatic random_zone();
        coord_t al, ah, el, eh;
        al = pick_coord();
        ah = al + coord_t'($urandom_range(0, 20000));
        el = pick_coord();
        eh = el + coord_t'($urandom_range(0, 20000));
        if ($urandom_range(0, 9) == 0) begin al = coord_t'($urandom); ah = coord_t'($urandom); end
        if ($urandom_range(0, 9) == 0) begin el = coord_t'($urandom); eh = coord_t'($urandom); end
        load_zone(4'($urandom), $urandom_range(0, 4) != 0, al, ah, el, eh);
    endtask

    task automatic random_check();
        coord_t sa, se, ea, ee;
        sa = pick_coord(); se = pick_coord();
        ea = pick_coord(); ee = pick_coord();
        case ($urandom_range(0, 7))
            0: ea = sa;
            1: ee = se;
            2: ea = sa + (($urandom_range(0, 1)) ? coord_t'(FULL_TURN) : -coord_t'(FULL_TURN));
            default: ;
        endcase
        check_path(sa, se, ea, ee);
    endtask

    initial
    begin
        errors = 0;
        board = new();
        rst_n = 1'b0; start = 1'b0; cfg_valid = 1'b0;
        cfg_index = REG_MOTION_PROFILE; cfg_data = '0;
        req_type = REQ_LOAD; zone_slot = '0; zone_enable = 1'b0;
        zone_az_low = '0; zone_az_high = '0; zone_el_low = '0; zone_el_high = '0;
        start_az = '0; start_el = '0; end_az = '0; end_el = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, then a simple box and its edges
        check_path(-131072, -131072, 131071, 131071);
        load_zone(0, 1, -1000, 1000, -1000, 1000);
        check_path(-5000, 0, 5000, 0);
        check_path(-5000, 1000, 5000, 1000);
        check_path(0, -5000, 0, 5000);
        check_path(1000, -5000, 1000, 5000);
        check_path(-3000, -3000, 3000, 3000);
        check_path(-3000, 2000, 3000, 2000);
        // reversed bounds
        load_zone(1, 1, 20000, 10000, 30000, 20000);
        check_path(15000, 0, 15000, 50000);
        check_path(0, 25000, 30000, 25000);
        // extreme bounds, disabled and enabled
        load_zone(15, 0, -131072, 131071, -131072, 131071);
        check_path(-131072, 131071, 131071, -131072);
        load_zone(15, 1, -131072, 131071, -131072, 131071);
        check_path(5, 5, 5, 5);
        load_zone(15, 0, 131071, -131072, 131071, -131072);
        drain();

        // seam cases with wrap on
        write_reg(REG_AZIMUTH_WRAPS, 1);
        load_zone(2, 1, 44000, 46080, -500, 500);
        check_path(40000, 0, -40000, 0);
        check_path(-46080, 0, 46080, 0);
        check_path(46080, 100, -46080, -100);
        check_path(40000, -3000, -40000, 3001);
        check_path(-131072, 0, 131071, 0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_MOTION_PROFILE, 2'(ph % 4));
            write_reg(REG_AZIMUTH_WRAPS, 2'(ph / 4));
            for (int n = 0; n < 178; n++) begin
                idle_gap();
                if ($urandom_range(0, 9) < 3) random_zone();
                else random_check();
                if (n == 90) drain();
            end
            drain();
        end

        $display("covered %0d zone loads and %0d checked paths", board.loads_seen,
                 board.checks_seen);
        $display("over all four profile codes with azimuth wrap off and on");
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("tb failed");
        $finish;
    end

endmodule

/* sim.f */
sv/pcc_pkg.sv
sv/pcc_zone_cell.sv
sv/pcc_divider.sv
sv/path_clearance_checker_core.sv
tb/tb.sv
